FILE: design/tdma_slot_phase_sequencer_top_macros.svh
// Assertion macros for the TDMA slot phase sequencer.
// Included by the top level; needs no package.
`ifndef TDMA_SLOT_PHASE_SEQUENCER_TOP_MACROS_SVH
`define TDMA_SLOT_PHASE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define TSPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdma_sps: implication violated");

// next-cycle implication
`define TSPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdma_sps: next-cycle implication violated");

`endif

FILE: design/tdma_sps_pkg.sv
// Shared types and constants for the TDMA slot phase sequencer.
// Used by the serial divider and the top level; no dependencies.
`timescale 1ns / 1ps

package tdma_sps_pkg;

	localparam int SLOT_W    = 40;
	localparam int DIV_CNT_W = 6;
	localparam int ADDR_W    = 5;

	// item kinds
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_RESYNC = 2'd1;
	localparam logic [1:0] KIND_MISSED = 2'd2;

	typedef enum logic [2:0] {
		REG_BEACON_PERIOD   = 3'd0,
		REG_CYCLE_LENGTH    = 3'd1,
		REG_UPLOAD_SLOTS    = 3'd2,
		REG_DOWNLOAD_SLOTS  = 3'd3,
		REG_NODE_COUNT      = 3'd4,
		REG_OWN_SLOT        = 3'd5,
		REG_DOWNLOAD_FREQ   = 3'd6,
		REG_LOST_BCN_LIMIT  = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		PHASE_NONE     = 3'd0,
		PHASE_SYNC     = 3'd1,
		PHASE_UPLOAD   = 3'd2,
		PHASE_DOWNLOAD = 3'd3,
		PHASE_SLEEP    = 3'd4
	} phase_t;

	localparam logic [15:0] BEACON_PERIOD_RST  = 16'd100;
	localparam logic [15:0] CYCLE_LENGTH_RST   = 16'd1000;
	localparam logic [15:0] UPLOAD_SLOTS_RST   = 16'd400;
	localparam logic [15:0] DOWNLOAD_SLOTS_RST = 16'd400;
	localparam logic [7:0]  NODE_COUNT_RST     = 8'd16;
	localparam logic [7:0]  OWN_SLOT_RST       = 8'd0;
	localparam logic [7:0]  DOWNLOAD_FREQ_RST  = 8'd3;
	localparam logic [7:0]  LOST_LIMIT_RST     = 8'd3;
	localparam logic [15:0] CYCLE_INDEX_RST    = 16'hFFFF;
	localparam logic [31:0] RESYNC_DL_START    = 32'd3;
	localparam logic [7:0]  MISSED_MAX         = 8'hFF;

	// divide lengths in bits of dividend
	localparam logic [DIV_CNT_W-1:0] DIV_LEN_40 = 6'd40;
	localparam logic [DIV_CNT_W-1:0] DIV_LEN_32 = 6'd32;
	localparam logic [DIV_CNT_W-1:0] DIV_LEN_16 = 6'd16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  sync_high;
		logic [31:0] sync_low;
	} cmd_t;

	typedef struct packed {
		phase_t      phase;
		logic        upload_turn;
		logic [7:0]  download_step;
		logic [15:0] slot_index;
		logic        dropped_out;
	} res_t;

	// dividend is left-aligned in 40 bits; len bits are consumed
	typedef struct packed {
		logic [SLOT_W-1:0]    dividend;
		logic [15:0]          divisor;
		logic [DIV_CNT_W-1:0] len;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [SLOT_W-1:0] quotient;
		logic [15:0]       remainder;
	} div_res_t;

endpackage

FILE: design/tdma_sps_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tdma_sps_pkg for the request and result structs.
`timescale 1ns / 1ps

module tdma_sps_div
	import tdma_sps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  div_req_t req,
	output div_res_t res
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [SLOT_W-1:0]    quo_q;
	logic [15:0]          rem_q;
	logic [15:0]          dvs_q;

	logic [16:0] shifted;
	logic [17:0] diff;
	logic        ge;

	assign shifted = {rem_q, quo_q[SLOT_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !diff[17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= req.len;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			// quotient bits shift in from the bottom as dividend bits leave the top
			quo_q <= {quo_q[SLOT_W-2:0], ge};
			rem_q <= ge ? diff[15:0] : shifted[15:0];
		end
	end

	assign res.busy      = (cnt_q != '0);
	assign res.done      = done_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

endmodule

FILE: design/tdma_slot_phase_sequencer_top.sv
`timescale 1ns / 1ps
// TDMA slot phase sequencer, node side.
// Command channel (cmd_valid/cmd_stall/cmd): slot tick, resync with a 40-bit
// slot number, or missed beacon. Result channel (res_valid/res_stall/res):
// one item per command with phase, upload turn, download step, slot index
// and drop-out flag. Registers sit on the APB port at 4*index.
// One command is worked at a time; cmd_stall is high while it is in flight.
// All modulo and ceiling work runs on one serial divider, one bit a cycle:
//   sync tick        40-bit slot mod beacon period
//   upload tick      plus 16-bit (index + 1) mod node count
//   download tick    plus 32-bit count mod frequency
//   sleep tick       40-bit slot mod beacon period
//   resync           two 32-bit divides
//   missed beacon    no divide, nor for an unassociated tick or unused kind
// Results land in an output register, so the next command is taken while a
// result is still held by a stalling receiver; that command then waits for
// the register before it finishes. Reset loads the register defaults,
// leaves the node unassociated with index all ones, and clears both channels.
// Depends on tdma_sps_pkg and tdma_sps_div.

`include "tdma_slot_phase_sequencer_top_macros.svh"

module tdma_slot_phase_sequencer_top
	import tdma_sps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_t              cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_TICK_BP = 7'b0000010,
		S_TICK_UP = 7'b0000100,
		S_TICK_DL = 7'b0001000,
		S_RS_CEIL = 7'b0010000,
		S_RS_MOD  = 7'b0100000,
		S_FINISH  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] beacon_period_q, cycle_length_q, upload_slots_q, download_slots_q;
	logic [7:0]  node_count_q, own_slot_q, download_freq_q, lost_limit_q;

	// sequencer state
	logic [SLOT_W-1:0] slot_number_q;
	logic [15:0]       cycle_index_q;
	logic [31:0]       download_count_q;
	logic [7:0]        missed_q;
	logic              assoc_q;

	logic [1:0]        kind_q;
	logic [SLOT_W-1:0] sync_q;
	res_t              res_q;
	res_t              out_q;
	logic              out_valid_q;

	div_req_t div_req;
	div_res_t div_res;
	logic     div_start;

	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	logic              accept;
	logic              out_free;
	logic [15:0]       bp_nz, cl_nz;
	logic [7:0]        nc_nz, df_nz;
	logic [15:0]       idx_w;
	logic [16:0]       ud_sum;
	logic              is_up, is_dl;
	logic [31:0]       c_val;
	logic [7:0]        missed_inc;
	logic              drop;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[4:2]);
	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	// a zero modulus acts as one
	assign bp_nz = (beacon_period_q == '0) ? 16'd1 : beacon_period_q;
	assign cl_nz = (cycle_length_q == '0) ? 16'd1 : cycle_length_q;
	assign nc_nz = (node_count_q == '0) ? 8'd1 : node_count_q;
	assign df_nz = (download_freq_q == '0) ? 8'd1 : download_freq_q;

	assign idx_w  = (cycle_index_q >= cycle_length_q) ? 16'd0 : cycle_index_q;
	assign ud_sum = {1'b0, upload_slots_q} + {1'b0, download_slots_q};
	assign is_up  = idx_w < upload_slots_q;
	assign is_dl  = !is_up && ({1'b0, idx_w} < ud_sum);

	// a - ceil(a / period)
	assign c_val = sync_q[31:0] - div_res.quotient[31:0]
		- {31'd0, (div_res.remainder != '0)};

	assign missed_inc = (missed_q == MISSED_MAX) ? MISSED_MAX : missed_q + 8'd1;
	assign drop       = (missed_inc >= lost_limit_q);

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_BEACON_PERIOD:  prdata = {16'd0, beacon_period_q};
			REG_CYCLE_LENGTH:   prdata = {16'd0, cycle_length_q};
			REG_UPLOAD_SLOTS:   prdata = {16'd0, upload_slots_q};
			REG_DOWNLOAD_SLOTS: prdata = {16'd0, download_slots_q};
			REG_NODE_COUNT:     prdata = {24'd0, node_count_q};
			REG_OWN_SLOT:       prdata = {24'd0, own_slot_q};
			REG_DOWNLOAD_FREQ:  prdata = {24'd0, download_freq_q};
			REG_LOST_BCN_LIMIT: prdata = {24'd0, lost_limit_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beacon_period_q  <= BEACON_PERIOD_RST;
			cycle_length_q   <= CYCLE_LENGTH_RST;
			upload_slots_q   <= UPLOAD_SLOTS_RST;
			download_slots_q <= DOWNLOAD_SLOTS_RST;
			node_count_q     <= NODE_COUNT_RST;
			own_slot_q       <= OWN_SLOT_RST;
			download_freq_q  <= DOWNLOAD_FREQ_RST;
			lost_limit_q     <= LOST_LIMIT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BEACON_PERIOD:  beacon_period_q  <= pwdata[15:0];
				REG_CYCLE_LENGTH:   cycle_length_q   <= pwdata[15:0];
				REG_UPLOAD_SLOTS:   upload_slots_q   <= pwdata[15:0];
				REG_DOWNLOAD_SLOTS: download_slots_q <= pwdata[15:0];
				REG_NODE_COUNT:     node_count_q     <= pwdata[7:0];
				REG_OWN_SLOT:       own_slot_q       <= pwdata[7:0];
				REG_DOWNLOAD_FREQ:  download_freq_q  <= pwdata[7:0];
				REG_LOST_BCN_LIMIT: lost_limit_q     <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// divider requests
	always_comb begin
		div_start = 1'b0;
		div_req   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.kind == KIND_TICK && assoc_q) begin
					div_start = 1'b1;
					div_req   = '{dividend: slot_number_q, divisor: bp_nz, len: DIV_LEN_40};
				end else if (accept && cmd.kind == KIND_RESYNC) begin
					div_start = 1'b1;
					div_req   = '{dividend: {cmd.sync_low, 8'd0}, divisor: bp_nz,
						len: DIV_LEN_32};
				end
			end
			S_TICK_BP: begin
				if (div_res.done && div_res.remainder != '0) begin
					if (is_up) begin
						div_start = 1'b1;
						div_req   = '{dividend: {idx_w + 16'd1, 24'd0},
							divisor: {8'd0, nc_nz}, len: DIV_LEN_16};
					end else if (is_dl) begin
						div_start = 1'b1;
						div_req   = '{dividend: {download_count_q, 8'd0},
							divisor: {8'd0, df_nz}, len: DIV_LEN_32};
					end
				end
			end
			S_RS_CEIL: begin
				if (div_res.done) begin
					div_start = 1'b1;
					div_req   = '{dividend: {c_val, 8'd0}, divisor: cl_nz, len: DIV_LEN_32};
				end
			end
			default: ;
		endcase
	end

	tdma_sps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.res    (div_res)
	);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			slot_number_q    <= '0;
			cycle_index_q    <= CYCLE_INDEX_RST;
			download_count_q <= '0;
			missed_q         <= '0;
			assoc_q          <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			out_valid_q <= (state_q == S_FINISH && out_free) || (out_valid_q && res_stall);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd.kind == KIND_TICK && assoc_q) begin
							state_q <= S_TICK_BP;
						end else if (cmd.kind == KIND_RESYNC) begin
							state_q <= S_RS_CEIL;
						end else if (cmd.kind == KIND_MISSED && assoc_q) begin
							missed_q <= missed_inc;
							if (drop)
								assoc_q <= 1'b0;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_TICK_BP: begin
					if (div_res.done) begin
						slot_number_q <= slot_number_q + SLOT_W'(1);
						if (div_res.remainder == '0) begin
							state_q <= S_FINISH;
						end else begin
							cycle_index_q <= idx_w + 16'd1;
							if (is_up) begin
								state_q <= S_TICK_UP;
							end else if (is_dl) begin
								download_count_q <= download_count_q + 32'd1;
								state_q          <= S_TICK_DL;
							end else begin
								state_q <= S_FINISH;
							end
						end
					end
				end
				S_TICK_UP, S_TICK_DL: begin
					if (div_res.done)
						state_q <= S_FINISH;
				end
				S_RS_CEIL: begin
					if (div_res.done)
						state_q <= S_RS_MOD;
				end
				S_RS_MOD: begin
					if (div_res.done) begin
						cycle_index_q    <= div_res.remainder;
						slot_number_q    <= sync_q;
						download_count_q <= RESYNC_DL_START;
						missed_q         <= '0;
						assoc_q          <= 1'b1;
						state_q          <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= cmd.kind;
					sync_q <= {cmd.sync_high, cmd.sync_low};
					res_q  <= '{phase: PHASE_NONE, upload_turn: 1'b0, download_step: 8'd0,
						slot_index: cycle_index_q,
						dropped_out: (cmd.kind == KIND_MISSED) && assoc_q && drop};
				end
			end
			S_TICK_BP: begin
				if (div_res.done && div_res.remainder == '0) begin
					res_q.phase <= PHASE_SYNC;
				end else if (div_res.done) begin
					res_q.slot_index <= idx_w;
					if (is_up)
						res_q.phase <= PHASE_UPLOAD;
					else if (is_dl)
						res_q.phase <= PHASE_DOWNLOAD;
					else
						res_q.phase <= PHASE_SLEEP;
				end
			end
			S_TICK_UP: begin
				if (div_res.done)
					res_q.upload_turn <= (div_res.remainder[7:0] == own_slot_q);
			end
			S_TICK_DL: begin
				if (div_res.done)
					res_q.download_step <= div_res.remainder[7:0];
			end
			S_RS_MOD: begin
				if (div_res.done)
					res_q.slot_index <= div_res.remainder;
			end
			S_FINISH: begin
				if (out_free)
					out_q <= res_q;
			end
			default: ;
		endcase
	end

	`TSPS_ASSERT_IMP(a_div_busy_in_div_state, clk, arst_n, div_res.busy,
		state_q == S_TICK_BP || state_q == S_TICK_UP || state_q == S_TICK_DL ||
		state_q == S_RS_CEIL || state_q == S_RS_MOD)
	`TSPS_ASSERT_IMP(a_res_from_finish, clk, arst_n, $rose(res_valid),
		$past(state_q) == S_FINISH)
	`TSPS_ASSERT_IMP(a_resync_kind, clk, arst_n,
		state_q == S_RS_CEIL || state_q == S_RS_MOD, kind_q == KIND_RESYNC)
	`TSPS_ASSERT_NXT(a_finish_leaves, clk, arst_n,
		state_q == S_FINISH && out_free, state_q == S_IDLE && res_valid)

endmodule

FILE: test/tb_tdma_slot_phase_sequencer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for tdma_slot_phase_sequencer_top: directed slot
// sequences, extreme register settings and long random traffic with idling.
// Depends on tdma_sps_pkg and the sequencer RTL.

module tb_tdma_slot_phase_sequencer_top;
	import tdma_sps_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	cmd_t              cmd = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_t              res;

	// sequencer state as the block should hold it
	logic [39:0] slot_no = '0;
	logic [15:0] cyc_index = CYCLE_INDEX_RST;
	logic [31:0] dl_count = '0;
	logic [7:0]  missed_cnt = '0;
	logic        node_assoc = 1'b0;

	logic [15:0] cfg_period = BEACON_PERIOD_RST;
	logic [15:0] cfg_cycle_len = CYCLE_LENGTH_RST;
	logic [15:0] cfg_upload = UPLOAD_SLOTS_RST;
	logic [15:0] cfg_download = DOWNLOAD_SLOTS_RST;
	logic [7:0]  cfg_nodes = NODE_COUNT_RST;
	logic [7:0]  cfg_own = OWN_SLOT_RST;
	logic [7:0]  cfg_dl_freq = DOWNLOAD_FREQ_RST;
	logic [7:0]  cfg_lost_limit = LOST_LIMIT_RST;

	res_t        slot_results_due[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned gap_max = 0;
	int unsigned burst_left = 0;

	tdma_slot_phase_sequencer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		case (stall_mode)
			STALL_NONE: res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= ((cycle_count % 7) < 3);
		endcase
	end

	// Works out the result of one item and advances the sequencer state.
	function automatic res_t next_slot_result(input cmd_t c);
		res_t r;
		int unsigned per, idx, nodes, freq, span, a, b, ceil_q, len;
		logic business;
		r = '0;
		business = 1'b0;
		if (c.kind == KIND_TICK && node_assoc) begin
			per = (cfg_period == '0) ? 1 : 32'(cfg_period);
			if ((slot_no % 40'(per)) == '0) begin
				r.phase = PHASE_SYNC;
			end else begin
				business = 1'b1;
				idx = (cyc_index >= cfg_cycle_len) ? 0 : 32'(cyc_index);
				span = 32'(cfg_upload) + 32'(cfg_download);
				if (idx < 32'(cfg_upload)) begin
					r.phase = PHASE_UPLOAD;
					nodes = (cfg_nodes == '0) ? 1 : 32'(cfg_nodes);
					r.upload_turn = (((idx + 1) % nodes) == 32'(cfg_own));
				end else if (idx < span) begin
					r.phase = PHASE_DOWNLOAD;
					freq = (cfg_dl_freq == '0) ? 1 : 32'(cfg_dl_freq);
					r.download_step = 8'(dl_count % freq);
					dl_count = dl_count + 1;
				end else begin
					r.phase = PHASE_SLEEP;
				end
				r.slot_index = 16'(idx);
				cyc_index = 16'(idx + 1);
			end
			slot_no = slot_no + 40'd1;
		end else if (c.kind == KIND_RESYNC) begin
			a = c.sync_low;
			b = (cfg_period == '0) ? 1 : 32'(cfg_period);
			// exact ceiling, no a + b - 1 overflow
			ceil_q = a / b + (((a % b) != 0) ? 1 : 0);
			len = (cfg_cycle_len == '0) ? 1 : 32'(cfg_cycle_len);
			slot_no = {c.sync_high, c.sync_low};
			dl_count = RESYNC_DL_START;
			cyc_index = 16'((a - ceil_q) % len);
			missed_cnt = '0;
			node_assoc = 1'b1;
		end else if (c.kind == KIND_MISSED && node_assoc) begin
			if (missed_cnt != MISSED_MAX)
				missed_cnt = missed_cnt + 8'd1;
			if (missed_cnt >= cfg_lost_limit) begin
				node_assoc = 1'b0;
				r.dropped_out = 1'b1;
			end
		end
		if (!business)
			r.slot_index = cyc_index;
		return r;
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (slot_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected slot result at cycle %0d", cycle_count);
			end else begin
				want = slot_results_due.pop_front();
				if (res.phase !== want.phase || res.upload_turn !== want.upload_turn ||
						res.download_step !== want.download_step ||
						res.slot_index !== want.slot_index ||
						res.dropped_out !== want.dropped_out) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("slot result mismatch at cycle %0d", cycle_count);
						$display("  exp phase=%0d turn=%0b step=%0d index=%0d drop=%0b",
							want.phase, want.upload_turn, want.download_step,
							want.slot_index, want.dropped_out);
						$display("  got phase=%0d turn=%0b step=%0d index=%0d drop=%0b",
							res.phase, res.upload_turn, res.download_step,
							res.slot_index, res.dropped_out);
					end
				end
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		logic [31:0] wide;
		wide = $urandom;
		case (idx)
			REG_BEACON_PERIOD, REG_CYCLE_LENGTH, REG_UPLOAD_SLOTS, REG_DOWNLOAD_SLOTS:
				wide[15:0] = val;
			default: wide[7:0] = val[7:0];
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= wide;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_BEACON_PERIOD: cfg_period = val;
			REG_CYCLE_LENGTH: cfg_cycle_len = val;
			REG_UPLOAD_SLOTS: cfg_upload = val;
			REG_DOWNLOAD_SLOTS: cfg_download = val;
			REG_NODE_COUNT: cfg_nodes = val[7:0];
			REG_OWN_SLOT: cfg_own = val[7:0];
			REG_DOWNLOAD_FREQ: cfg_dl_freq = val[7:0];
			default: cfg_lost_limit = val[7:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_config(input logic [15:0] period, cyc_len, upload, download,
			nodes, own, freq, limit);
		write_reg(REG_BEACON_PERIOD, period);
		write_reg(REG_CYCLE_LENGTH, cyc_len);
		write_reg(REG_UPLOAD_SLOTS, upload);
		write_reg(REG_DOWNLOAD_SLOTS, download);
		write_reg(REG_NODE_COUNT, nodes);
		write_reg(REG_OWN_SLOT, own);
		write_reg(REG_DOWNLOAD_FREQ, freq);
		write_reg(REG_LOST_BCN_LIMIT, limit);
	endtask

	function automatic cmd_t make_item(input logic [1:0] kind, input logic [7:0] high,
			input logic [31:0] low);
		cmd_t c;
		c.kind = kind;
		c.sync_high = high;
		c.sync_low = low;
		return c;
	endfunction

	// Sender works in bursts; a gap drops valid for a random number of cycles.
	task automatic send_item(input cmd_t item);
		if (gap_max != 0 && burst_left == 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max) - 1) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd <= item;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		slot_results_due.push_back(next_slot_result(item));
		if (burst_left != 0)
			burst_left--;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (slot_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed_defaults();
		gap_max = 8;
		stall_mode = STALL_LIGHT;
		// ignored while not associated, and the unused kind
		send_item(make_item(KIND_TICK, 8'hFF, 32'hFFFF_FFFF));
		send_item(make_item(KIND_MISSED, 8'h00, 32'h0));
		send_item(make_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF));
		// slot 0: sync, then upload slots
		send_item(make_item(KIND_RESYNC, 8'h00, 32'd0));
		repeat (3) send_item(make_item(KIND_TICK, 8'h00, 32'd0));
		// index 15 is this node's upload turn
		send_item(make_item(KIND_RESYNC, 8'h00, 32'd16));
		send_item(make_item(KIND_TICK, 8'h00, 32'd0));
		send_item(make_item(KIND_RESYNC, 8'h00, 32'd500));
		repeat (3) send_item(make_item(KIND_TICK, 8'h00, 32'd0));
		send_item(make_item(KIND_RESYNC, 8'h00, 32'd900));
		repeat (2) send_item(make_item(KIND_TICK, 8'h00, 32'd0));
		// top slot number, wraps to zero
		send_item(make_item(KIND_RESYNC, 8'hFF, 32'hFFFF_FFFF));
		repeat (3) send_item(make_item(KIND_TICK, 8'h00, 32'd0));
		repeat (3) send_item(make_item(KIND_MISSED, 8'h00, 32'd0));
		send_item(make_item(KIND_TICK, 8'h00, 32'd0));
		drain();
	endtask

	task automatic short_run(input int unsigned ticks);
		send_item(make_item(KIND_RESYNC, 8'($urandom), $urandom));
		repeat (ticks) send_item(make_item(KIND_TICK, 8'($urandom), $urandom));
		repeat (2) send_item(make_item(KIND_MISSED, 8'($urandom), $urandom));
		send_item(make_item(KIND_TICK, 8'($urandom), $urandom));
		drain();
	endtask

	task automatic test_config_extremes();
		stall_mode = STALL_PERIODIC;
		gap_max = 0;
		// zero moduli act as one; zero loss limit drops on first miss
		apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		short_run(3);
		apply_config(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFF);
		short_run(3);
		apply_config(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFF, 16'hFF, 16'hFF, 16'hFF);
		short_run(3);
	endtask

	task automatic random_config(input logic full);
		logic [15:0] cl, nodes;
		if (full) begin
			apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
				16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
		end else begin
			cl = 16'($urandom_range(1, 40));
			nodes = 16'($urandom_range(1, 8));
			apply_config(16'($urandom_range(1, 15)), cl, 16'($urandom_range(0, cl)),
				16'($urandom_range(0, cl)), nodes, 16'($urandom_range(0, nodes)),
				16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
		end
	endtask

	function automatic cmd_t random_item();
		cmd_t c;
		int unsigned roll;
		c.sync_high = 8'($urandom);
		c.sync_low = $urandom;
		roll = $urandom_range(0, 99);
		if (!node_assoc && $urandom_range(0, 1))
			c.kind = KIND_RESYNC;
		else if (roll < 78)
			c.kind = KIND_TICK;
		else if (roll < 86)
			c.kind = KIND_RESYNC;
		else if (roll < 96)
			c.kind = KIND_MISSED;
		else
			c.kind = KIND_UNUSED;
		if (c.kind == KIND_RESYNC && $urandom_range(0, 1))
			c.sync_low = $urandom_range(0, 100000);
		return c;
	endfunction

	task automatic test_random_traffic();
		int unsigned counted;
		cmd_t item;
		for (int p = 0; p < 10; p++) begin
			if (p == 0) begin
				// a stretch with no idling on either side
				apply_config(16'd7, 16'd24, 16'd9, 16'd8, 16'd5, 16'd2, 16'd4, 16'd4);
				stall_mode = STALL_NONE;
				gap_max = 0;
			end else begin
				random_config(p % 4 == 3);
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0: gap_max = 0;
					1: gap_max = 8;
					2: gap_max = 60;
					default: gap_max = 120;
				endcase
			end
			counted = 0;
			while (counted < 195) begin
				item = random_item();
				counted++;
				send_item(item);
			end
			// hold off until every result of the phase is back
			drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_defaults();
		test_config_extremes();
		test_random_traffic();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0 && slot_results_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/tdma_sps_pkg.sv
design/tdma_sps_div.sv
design/tdma_slot_phase_sequencer_top.sv
test/tb_tdma_slot_phase_sequencer_top.sv
